### src/pic_pkg.sv
// Shared widths, register map and beat types of the point-in-cylinder test.
`default_nettype none

package pic_pkg;

  // Coordinate width and the widths that follow from it.
  localparam int unsigned CoordW    = 16;
  localparam int unsigned DiffW     = CoordW + 1;          // d = P - B, a = T - B
  localparam int unsigned ProdW     = 2 * DiffW;           // one coordinate product
  localparam int unsigned DotW      = ProdW + 2;           // sum of three products
  localparam int unsigned CrossW    = ProdW + 1;           // one cross product component
  localparam int unsigned CrossLoW  = CrossW / 2;
  localparam int unsigned CrossHiW  = CrossW - CrossLoW;
  localparam int unsigned RadW      = 15;
  localparam int unsigned RrW       = 2 * RadW;            // radius squared
  localparam int unsigned AaLoW     = DotW / 2;
  localparam int unsigned AaHiW     = DotW - AaLoW;
  localparam int unsigned SqW       = 2 * CrossW + 1;      // one squared cross component
  localparam int unsigned PerpW     = SqW + 2;             // squared distance times |a|^2
  localparam int unsigned LimW      = RrW + DotW + 1;      // r^2 times |a|^2
  localparam int unsigned CmpW      = ((PerpW > LimW) ? PerpW : LimW) + 1;

  // Configuration port.
  localparam int unsigned DataW     = 32;
  localparam int unsigned NumRegs   = 7;
  localparam int unsigned RegIdxW   = $clog2(NumRegs);
  localparam int unsigned AddrW     = RegIdxW + 2;

  localparam logic [RegIdxW-1:0] RegBottomX = RegIdxW'(0);
  localparam logic [RegIdxW-1:0] RegBottomY = RegIdxW'(1);
  localparam logic [RegIdxW-1:0] RegBottomZ = RegIdxW'(2);
  localparam logic [RegIdxW-1:0] RegTopX    = RegIdxW'(3);
  localparam logic [RegIdxW-1:0] RegTopY    = RegIdxW'(4);
  localparam logic [RegIdxW-1:0] RegTopZ    = RegIdxW'(5);
  localparam logic [RegIdxW-1:0] RegRadius  = RegIdxW'(6);

  localparam logic signed [CoordW-1:0] TopZReset   = CoordW'(256);
  localparam logic        [RadW-1:0]   RadiusReset = RadW'(256);

  // Input beat: one query point.
  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } pic_in_t;

  // Output beat: one test result.
  typedef struct packed {
    logic inside_res;
    logic axis_degenerate;
  } pic_out_t;

  // Cylinder setup as held in the register file.
  typedef struct packed {
    logic signed [CoordW-1:0] bottom_x;
    logic signed [CoordW-1:0] bottom_y;
    logic signed [CoordW-1:0] bottom_z;
    logic signed [CoordW-1:0] top_x;
    logic signed [CoordW-1:0] top_y;
    logic signed [CoordW-1:0] top_z;
    logic        [RadW-1:0]   radius;
  } pic_cfg_t;

  // Dot products and cross product handed from the front to the back pipeline.
  typedef struct packed {
    logic signed [DotW-1:0]   da;
    logic signed [DotW-1:0]   aa;
    logic signed [CrossW-1:0] cross_x;
    logic signed [CrossW-1:0] cross_y;
    logic signed [CrossW-1:0] cross_z;
    logic        [RrW-1:0]    rr;
    logic                     degen;
  } pic_mid_t;

endpackage

`default_nettype wire

### src/pic_regs.sv
// APB register file holding the cylinder bottom, top and radius.
`default_nettype none

module pic_regs
  import pic_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output pic_cfg_t              cfg_o
);

  pic_cfg_t           cfg_q, cfg_d;
  logic [RegIdxW-1:0] idx;
  logic               wr_en;

  assign idx    = paddr[AddrW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register write decode; addresses past the last register are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegBottomX: cfg_d.bottom_x = pwdata[CoordW-1:0];
        RegBottomY: cfg_d.bottom_y = pwdata[CoordW-1:0];
        RegBottomZ: cfg_d.bottom_z = pwdata[CoordW-1:0];
        RegTopX:    cfg_d.top_x    = pwdata[CoordW-1:0];
        RegTopY:    cfg_d.top_y    = pwdata[CoordW-1:0];
        RegTopZ:    cfg_d.top_z    = pwdata[CoordW-1:0];
        RegRadius:  cfg_d.radius   = pwdata[RadW-1:0];
        default:    cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bottom_x <= '0;
      cfg_q.bottom_y <= '0;
      cfg_q.bottom_z <= '0;
      cfg_q.top_x    <= '0;
      cfg_q.top_y    <= '0;
      cfg_q.top_z    <= TopZReset;
      cfg_q.radius   <= RadiusReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux; coordinates come back sign-extended.
  always_comb begin
    case (idx)
      RegBottomX: prdata = DataW'(cfg_q.bottom_x);
      RegBottomY: prdata = DataW'(cfg_q.bottom_y);
      RegBottomZ: prdata = DataW'(cfg_q.bottom_z);
      RegTopX:    prdata = DataW'(cfg_q.top_x);
      RegTopY:    prdata = DataW'(cfg_q.top_y);
      RegTopZ:    prdata = DataW'(cfg_q.top_z);
      RegRadius:  prdata = DataW'(cfg_q.radius);
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### src/pic_front.sv
// Front pipeline: differences, coordinate products, dot and cross products.
`default_nettype none

module pic_front
  import pic_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire pic_cfg_t cfg_i,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire pic_in_t  in_beat_i,
  output logic          mid_valid_o,
  input  wire logic     mid_ready_i,
  output pic_mid_t      mid_beat_o
);

  // Stage handshake: a stage loads when it is empty or its successor loads.
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  assign rdy3       = !v3_q || mid_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Stage 1: offsets from the bottom centre, axis vector, radius squared.
  logic signed [DiffW-1:0] dx_d, dy_d, dz_d, ax_d, ay_d, az_d;
  logic signed [DiffW-1:0] dx_q, dy_q, dz_q, ax_q, ay_q, az_q;
  logic        [RrW-1:0]   rr1_d, rr1_q;
  logic                    dg1_d, dg1_q;

  always_comb begin
    dx_d  = DiffW'(in_beat_i.point_x) - DiffW'(cfg_i.bottom_x);
    dy_d  = DiffW'(in_beat_i.point_y) - DiffW'(cfg_i.bottom_y);
    dz_d  = DiffW'(in_beat_i.point_z) - DiffW'(cfg_i.bottom_z);
    ax_d  = DiffW'(cfg_i.top_x) - DiffW'(cfg_i.bottom_x);
    ay_d  = DiffW'(cfg_i.top_y) - DiffW'(cfg_i.bottom_y);
    az_d  = DiffW'(cfg_i.top_z) - DiffW'(cfg_i.bottom_z);
    rr1_d = RrW'(cfg_i.radius) * RrW'(cfg_i.radius);
    dg1_d = (cfg_i.top_x == cfg_i.bottom_x) && (cfg_i.top_y == cfg_i.bottom_y) &&
            (cfg_i.top_z == cfg_i.bottom_z);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      dz_q  <= dz_d;
      ax_q  <= ax_d;
      ay_q  <= ay_d;
      az_q  <= az_d;
      rr1_q <= rr1_d;
      dg1_q <= dg1_d;
    end
  end

  // Stage 2: the twelve coordinate products.
  logic signed [ProdW-1:0] pdx_d, pdy_d, pdz_d, pax_d, pay_d, paz_d;
  logic signed [ProdW-1:0] pyz_d, pzy_d, pzx_d, pxz_d, pxy_d, pyx_d;
  logic signed [ProdW-1:0] pdx_q, pdy_q, pdz_q, pax_q, pay_q, paz_q;
  logic signed [ProdW-1:0] pyz_q, pzy_q, pzx_q, pxz_q, pxy_q, pyx_q;
  logic        [RrW-1:0]   rr2_q;
  logic                    dg2_q;

  always_comb begin
    pdx_d = dx_q * ax_q;
    pdy_d = dy_q * ay_q;
    pdz_d = dz_q * az_q;
    pax_d = ax_q * ax_q;
    pay_d = ay_q * ay_q;
    paz_d = az_q * az_q;
    pyz_d = dy_q * az_q;
    pzy_d = dz_q * ay_q;
    pzx_d = dz_q * ax_q;
    pxz_d = dx_q * az_q;
    pxy_d = dx_q * ay_q;
    pyx_d = dy_q * ax_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      pdx_q <= pdx_d;
      pdy_q <= pdy_d;
      pdz_q <= pdz_d;
      pax_q <= pax_d;
      pay_q <= pay_d;
      paz_q <= paz_d;
      pyz_q <= pyz_d;
      pzy_q <= pzy_d;
      pzx_q <= pzx_d;
      pxz_q <= pxz_d;
      pxy_q <= pxy_d;
      pyx_q <= pyx_d;
      rr2_q <= rr1_q;
      dg2_q <= dg1_q;
    end
  end

  // Stage 3: d.a, |a|^2 and the cross product d x a.
  pic_mid_t mid_d, mid_q;

  always_comb begin
    mid_d.da      = DotW'(pdx_q) + DotW'(pdy_q) + DotW'(pdz_q);
    mid_d.aa      = DotW'(pax_q) + DotW'(pay_q) + DotW'(paz_q);
    mid_d.cross_x = CrossW'(pyz_q) - CrossW'(pzy_q);
    mid_d.cross_y = CrossW'(pzx_q) - CrossW'(pxz_q);
    mid_d.cross_z = CrossW'(pxy_q) - CrossW'(pyx_q);
    mid_d.rr      = rr2_q;
    mid_d.degen   = dg2_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      mid_q <= mid_d;
    end
  end

  assign mid_valid_o = v3_q;
  assign mid_beat_o  = mid_q;

  // The front only pushes back when every stage holds a beat.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q))
    else $error("front stalls its input while a stage is empty");

  // A beat blocked at the hand-off stays put until the back takes it.
  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !mid_ready_i) |=> (v3_q && $stable(mid_q)))
    else $error("front lost or changed a blocked beat");

  // Stage valid bits are always known once out of reset.
  a_valid_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({v1_q, v2_q, v3_q}))
    else $error("front stage valid bit is unknown");

endmodule

`default_nettype wire

### src/pic_back.sv
// Back pipeline: split squares of the cross product, limit, and final compare.
`default_nettype none

module pic_back
  import pic_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     mid_valid_i,
  output logic          mid_ready_o,
  input  wire pic_mid_t mid_beat_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output pic_out_t      out_beat_o
);

  // Stage handshake for stages 4 through 7; stage 7 is the output register.
  logic v4_q, v5_q, v6_q, v7_q;
  logic rdy4, rdy5, rdy6, rdy7;

  assign rdy7        = !v7_q || !out_stall_i;
  assign rdy6        = !v6_q || rdy7;
  assign rdy5        = !v5_q || rdy6;
  assign rdy4        = !v4_q || rdy5;
  assign mid_ready_o = rdy4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (rdy4) v4_q <= mid_valid_i;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
      if (rdy7) v7_q <= v6_q;
    end
  end

  // Stage 4: half-width partial products of each cross component squared
  // and of r^2 |a|^2, plus the axial range check.
  logic signed [CrossW-1:0]          cr [3];
  logic signed [CrossHiW-1:0]        chi [3];
  logic signed [CrossLoW:0]          clo [3];
  logic signed [2*CrossHiW-1:0]      hh_d [3], hh_q [3];
  logic signed [CrossW:0]            hl_d [3], hl_q [3];
  logic        [2*CrossLoW-1:0]      ll_d [3], ll_q [3];
  logic signed [AaHiW-1:0]           aa_hi;
  logic        [AaLoW-1:0]           aa_lo;
  logic signed [RrW:0]               rr_s;
  logic signed [AaHiW+RrW:0]         ph_d, ph_q;
  logic        [AaLoW+RrW-1:0]       pl_d, pl_q;
  logic                              rng4_d, rng4_q, dg4_q;

  always_comb begin
    cr[0] = mid_beat_i.cross_x;
    cr[1] = mid_beat_i.cross_y;
    cr[2] = mid_beat_i.cross_z;
    for (int i = 0; i < 3; i++) begin
      chi[i]  = cr[i][CrossW-1:CrossLoW];
      clo[i]  = {1'b0, cr[i][CrossLoW-1:0]};
      hh_d[i] = chi[i] * chi[i];
      hl_d[i] = chi[i] * clo[i];
      ll_d[i] = cr[i][CrossLoW-1:0] * cr[i][CrossLoW-1:0];
    end
    aa_hi  = mid_beat_i.aa[DotW-1:AaLoW];
    aa_lo  = mid_beat_i.aa[AaLoW-1:0];
    rr_s   = {1'b0, mid_beat_i.rr};
    ph_d   = aa_hi * rr_s;
    pl_d   = aa_lo * mid_beat_i.rr;
    rng4_d = !mid_beat_i.da[DotW-1] && (mid_beat_i.da <= mid_beat_i.aa);
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      hh_q   <= hh_d;
      hl_q   <= hl_d;
      ll_q   <= ll_d;
      ph_q   <= ph_d;
      pl_q   <= pl_d;
      rng4_q <= rng4_d;
      dg4_q  <= mid_beat_i.degen;
    end
  end

  // Stage 5: recombine each square and the limit from their halves.
  logic signed [SqW-1:0]  t_hh [3], t_hl [3], t_ll [3];
  logic signed [SqW-1:0]  sq_d [3], sq_q [3];
  logic signed [LimW-1:0] lim_hi, lim_lo, lim5_d, lim5_q;
  logic                   rng5_q, dg5_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_hh[i] = SqW'(hh_q[i]) <<< (2 * CrossLoW);
      t_hl[i] = SqW'(hl_q[i]) <<< (CrossLoW + 1);
      t_ll[i] = $signed({{(SqW - 2 * CrossLoW){1'b0}}, ll_q[i]});
      sq_d[i] = t_hh[i] + t_hl[i] + t_ll[i];
    end
    lim_hi = LimW'(ph_q) <<< AaLoW;
    lim_lo = $signed({{(LimW - AaLoW - RrW){1'b0}}, pl_q});
    lim5_d = lim_hi + lim_lo;
  end

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      sq_q   <= sq_d;
      lim5_q <= lim5_d;
      rng5_q <= rng4_q;
      dg5_q  <= dg4_q;
    end
  end

  // Stage 6: |d x a|^2, which equals |d|^2 |a|^2 - (d.a)^2.
  logic signed [PerpW-1:0] perp_d, perp_q;
  logic signed [LimW-1:0]  lim6_q;
  logic                    rng6_q, dg6_q;

  assign perp_d = PerpW'(sq_q[0]) + PerpW'(sq_q[1]) + PerpW'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (rdy6) begin
      perp_q <= perp_d;
      lim6_q <= lim5_q;
      rng6_q <= rng5_q;
      dg6_q  <= dg5_q;
    end
  end

  // Stage 7: radial compare and result register.
  pic_out_t res_d, res_q;

  always_comb begin
    res_d.axis_degenerate = dg6_q;
    res_d.inside_res      = !dg6_q && rng6_q && (CmpW'(perp_q) <= CmpW'(lim6_q));
  end

  always_ff @(posedge clk_i) begin
    if (rdy7) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = v7_q;
  assign out_beat_o  = res_q;

  // A degenerate axis never reports a point inside.
  a_degen_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_beat_o.axis_degenerate) |-> !out_beat_o.inside_res)
    else $error("inside reported for a degenerate axis");

  // A result only appears when the stage before it held a beat.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(v7_q) |-> $past(v6_q))
    else $error("result appeared without a beat behind it");

  // A beat in the middle of the back pipeline moves on or holds, never vanishes.
  a_mid_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && !rdy6) |=> (v5_q && $stable(sq_q[0]) && $stable(lim5_q)))
    else $error("stalled stage five beat was lost or changed");

endmodule

`default_nettype wire

### src/point_in_cylinder_test.sv
// Top level of the point-in-finite-cylinder test.
`default_nettype none

// Tests one signed Q8.8 point per beat against a finite cylinder given by a
// bottom centre, a top centre and a radius written over the APB port. The
// test is exact: with d = P - B and a = T - B it checks 0 <= d.a <= |a|^2 and
// |d x a|^2 <= r^2 |a|^2 in full-width integers, and flags a top equal to the
// bottom as degenerate with inside forced low. One point is accepted every
// cycle while no stage stalls; each result reaches the output register
// through the seven-stage multiplier pipeline (differences, products,
// dot and cross sums, half-width partial squares, recombination, final sum,
// compare). Each stage holds its beat under stall, so input stall rises only
// when all seven stages are occupied. Register writes apply to points
// accepted after the write.

module point_in_cylinder_test
  import pic_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire pic_in_t          in_beat_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output pic_out_t              out_beat_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);

  pic_cfg_t cfg;
  pic_mid_t mid_beat;
  logic     mid_valid;
  logic     mid_ready;
  logic     in_ready;

  assign in_stall_o = !in_ready;

  // Cylinder setup registers.
  pic_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Dot and cross products.
  pic_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .in_beat_i   (in_beat_i),
    .mid_valid_o (mid_valid),
    .mid_ready_i (mid_ready),
    .mid_beat_o  (mid_beat)
  );

  // Squares, limit and compare.
  pic_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_valid_i (mid_valid),
    .mid_ready_o (mid_ready),
    .mid_beat_i  (mid_beat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

`default_nettype wire
